### design/strings_file_pair_parser_assert.svh
// ----------------------------------------------------------------------------
// Strings catalog parser assertion macros
// Clocked assertion wrappers for the parser top module.
// ----------------------------------------------------------------------------
`ifndef STRINGS_FILE_PAIR_PARSER_ASSERT_SVH
`define STRINGS_FILE_PAIR_PARSER_ASSERT_SVH

// Checked only while out of reset
`define SFPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included
`define SFPP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/sfpp_pkg.sv
// ----------------------------------------------------------------------------
// Strings catalog parser package
// Phase, event and error codes, result word and helper functions.
// ----------------------------------------------------------------------------
package sfpp_pkg;

    // Parse phase
    typedef enum logic [3:0] {
        PH_BETWEEN = 4'd0,
        PH_SLASH   = 4'd1,
        PH_COMMENT = 4'd2,
        PH_CSTAR   = 4'd3,
        PH_KEY     = 4'd4,
        PH_KESC    = 4'd5,
        PH_KOCT1   = 4'd6,
        PH_KOCT2   = 4'd7,
        PH_SEP1    = 4'd8,
        PH_SEP2    = 4'd9,
        PH_TEXT    = 4'd10,
        PH_TESC    = 4'd11,
        PH_TOCT1   = 4'd12,
        PH_TOCT2   = 4'd13,
        PH_TERM    = 4'd14,
        PH_HALT    = 4'd15
    } t_phase;

    // Output event codes
    typedef enum logic [2:0] {
        EV_KEY_CHAR  = 3'd0,
        EV_TEXT_CHAR = 3'd1,
        EV_KEY_DONE  = 3'd2,
        EV_PAIR_DONE = 3'd3,
        EV_ERROR     = 3'd4,
        EV_END_OK    = 3'd5
    } t_event;

    // Error codes
    typedef enum logic [2:0] {
        ERR_SYNTAX   = 3'd0,
        ERR_KEY_ESC  = 3'd1,
        ERR_OPEN_KEY = 3'd2,
        ERR_NO_SEP   = 3'd3,
        ERR_NO_TEXT  = 3'd4,
        ERR_TEXT_ESC = 3'd5,
        ERR_OPEN_TXT = 3'd6,
        ERR_NO_TERM  = 3'd7
    } t_err;

    localparam int          LINE_W   = 20;
    localparam logic [19:0] LINE_MAX = 20'hFFFFF;
    localparam int          OCT_W    = 5;

    // Characters of interest
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    // Live parse state, apart from the string length
    typedef struct packed {
        t_phase             phase;
        logic [OCT_W-1:0]   oct;
        logic [LINE_W-1:0]  line;
    } t_parse_state;

    // One result word
    typedef struct packed {
        t_event             event_res;
        logic [7:0]         out_char;
        t_err               error_code;
        logic [LINE_W-1:0]  line_number;
    } t_result;

    // Step logic to output register
    typedef struct packed {
        logic    valid;
        t_result word;
    } t_step_res;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        is_octal = (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

    // Line count after byte c, saturating
    function automatic logic [LINE_W-1:0] bump_line(input logic [LINE_W-1:0] line,
                                                    input logic [7:0] c);
        if ((c == CH_LF) && (line != LINE_MAX)) begin
            bump_line = line + LINE_W'(1);
        end else begin
            bump_line = line;
        end
    endfunction

    // Error reported when data ends in a given phase
    function automatic t_err end_error(input t_phase p);
        case (p)
            PH_KEY, PH_KESC:             end_error = ERR_OPEN_KEY;
            PH_KOCT1, PH_KOCT2:          end_error = ERR_KEY_ESC;
            PH_SEP1:                     end_error = ERR_NO_SEP;
            PH_SEP2:                     end_error = ERR_NO_TEXT;
            PH_TEXT:                     end_error = ERR_OPEN_TXT;
            PH_TESC, PH_TOCT1, PH_TOCT2: end_error = ERR_TEXT_ESC;
            PH_TERM:                     end_error = ERR_NO_TERM;
            default:                     end_error = ERR_SYNTAX;
        endcase
    endfunction

endpackage

### design/sfpp_in_if.sv
// ----------------------------------------------------------------------------
// Strings catalog parser input channel
// Valid/ready channel carrying one catalog byte and the end marker.
// ----------------------------------------------------------------------------
interface sfpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

### design/sfpp_out_if.sv
// ----------------------------------------------------------------------------
// Strings catalog parser output channel
// Valid/ready channel carrying one parse event word.
// ----------------------------------------------------------------------------
interface sfpp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  out_char;
    logic [2:0]  error_code;
    logic [19:0] line_number;

    modport source (output valid, output event_res, output out_char,
                    output error_code, output line_number, input ready);
    modport sink   (input valid, input event_res, input out_char,
                    input error_code, input line_number, output ready);
endinterface

### design/sfpp_step.sv
// ----------------------------------------------------------------------------
// Strings catalog parser step logic
// Next parse state and the optional event word for one catalog byte.
// ----------------------------------------------------------------------------
module sfpp_step #(
    parameter int MAX_LEN = 1024,
    localparam int LEN_W  = $clog2(MAX_LEN)
) (
    input  sfpp_pkg::t_parse_state i_state,
    input  logic [LEN_W-1:0]       i_len,
    input  logic [7:0]             i_byte,
    input  logic                   i_eod,
    output sfpp_pkg::t_parse_state o_state,
    output logic [LEN_W-1:0]       o_len,
    output sfpp_pkg::t_step_res    o_res
);

    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_LEN - 1);

    logic             want_char;
    sfpp_pkg::t_event char_ev;
    logic [7:0]       char_val;
    logic             is_text;

    // Phase decode
    always_comb begin
        o_state   = i_state;
        o_len     = i_len;
        o_res     = '0;
        want_char = 1'b0;
        char_ev   = sfpp_pkg::EV_KEY_CHAR;
        char_val  = i_byte;
        is_text   = (i_state.phase == sfpp_pkg::PH_TEXT)  ||
                    (i_state.phase == sfpp_pkg::PH_TESC)  ||
                    (i_state.phase == sfpp_pkg::PH_TOCT1) ||
                    (i_state.phase == sfpp_pkg::PH_TOCT2);
        o_res.word.line_number = i_state.line;

        if (i_state.phase == sfpp_pkg::PH_HALT) begin
            // halted: nothing moves
        end else if (i_eod) begin
            o_state.phase = sfpp_pkg::PH_HALT;
            o_res.valid   = 1'b1;
            if ((i_state.phase == sfpp_pkg::PH_BETWEEN) ||
                (i_state.phase == sfpp_pkg::PH_COMMENT) ||
                (i_state.phase == sfpp_pkg::PH_CSTAR)) begin
                o_res.word.event_res = sfpp_pkg::EV_END_OK;
            end else begin
                o_res.word.event_res  = sfpp_pkg::EV_ERROR;
                o_res.word.error_code = sfpp_pkg::end_error(i_state.phase);
            end
        end else begin
            case (i_state.phase)
                sfpp_pkg::PH_BETWEEN: begin
                    if (sfpp_pkg::is_ws(i_byte)) begin
                        o_state.line = sfpp_pkg::bump_line(i_state.line, i_byte);
                    end else if (i_byte == sfpp_pkg::CH_SLASH) begin
                        o_state.phase = sfpp_pkg::PH_SLASH;
                    end else if (i_byte == sfpp_pkg::CH_QUOTE) begin
                        o_len         = '0;
                        o_state.phase = sfpp_pkg::PH_KEY;
                    end else begin
                        o_state.phase          = sfpp_pkg::PH_HALT;
                        o_res.valid            = 1'b1;
                        o_res.word.event_res   = sfpp_pkg::EV_ERROR;
                        o_res.word.error_code  = sfpp_pkg::ERR_SYNTAX;
                    end
                end
                sfpp_pkg::PH_SLASH: begin
                    if (i_byte == sfpp_pkg::CH_STAR) begin
                        o_state.phase = sfpp_pkg::PH_COMMENT;
                    end else begin
                        o_state.phase          = sfpp_pkg::PH_HALT;
                        o_res.valid            = 1'b1;
                        o_res.word.event_res   = sfpp_pkg::EV_ERROR;
                        o_res.word.error_code  = sfpp_pkg::ERR_SYNTAX;
                    end
                end
                sfpp_pkg::PH_COMMENT: begin
                    if (i_byte == sfpp_pkg::CH_STAR) begin
                        o_state.phase = sfpp_pkg::PH_CSTAR;
                    end else begin
                        o_state.line = sfpp_pkg::bump_line(i_state.line, i_byte);
                    end
                end
                sfpp_pkg::PH_CSTAR: begin
                    if (i_byte == sfpp_pkg::CH_SLASH) begin
                        o_state.phase = sfpp_pkg::PH_BETWEEN;
                    end else if (i_byte != sfpp_pkg::CH_STAR) begin
                        o_state.line  = sfpp_pkg::bump_line(i_state.line, i_byte);
                        o_state.phase = sfpp_pkg::PH_COMMENT;
                    end
                end
                sfpp_pkg::PH_KEY, sfpp_pkg::PH_TEXT: begin
                    if (i_byte == sfpp_pkg::CH_QUOTE) begin
                        if (is_text) begin
                            o_state.phase = sfpp_pkg::PH_TERM;
                        end else begin
                            o_state.phase        = sfpp_pkg::PH_SEP1;
                            o_res.valid          = 1'b1;
                            o_res.word.event_res = sfpp_pkg::EV_KEY_DONE;
                        end
                    end else if (i_byte == sfpp_pkg::CH_BSLASH) begin
                        o_state.phase = is_text ? sfpp_pkg::PH_TESC : sfpp_pkg::PH_KESC;
                    end else begin
                        want_char = 1'b1;
                    end
                end
                sfpp_pkg::PH_KESC, sfpp_pkg::PH_TESC: begin
                    o_state.phase = is_text ? sfpp_pkg::PH_TEXT : sfpp_pkg::PH_KEY;
                    if ((i_byte == sfpp_pkg::CH_BSLASH) || (i_byte == sfpp_pkg::CH_APOS) ||
                        (i_byte == sfpp_pkg::CH_QUOTE)) begin
                        want_char = 1'b1;
                    end else if (i_byte == sfpp_pkg::CH_N) begin
                        want_char = 1'b1;
                        char_val  = sfpp_pkg::CH_LF;
                    end else if (i_byte == sfpp_pkg::CH_R) begin
                        want_char = 1'b1;
                        char_val  = sfpp_pkg::CH_CR;
                    end else if (i_byte == sfpp_pkg::CH_T) begin
                        want_char = 1'b1;
                        char_val  = sfpp_pkg::CH_TAB;
                    end else if ((i_byte >= sfpp_pkg::CH_ZERO) &&
                                 (i_byte <= sfpp_pkg::CH_THREE)) begin
                        // first octal digit, 0..3
                        o_state.oct   = sfpp_pkg::OCT_W'(i_byte[1:0]);
                        o_state.phase = is_text ? sfpp_pkg::PH_TOCT1 : sfpp_pkg::PH_KOCT1;
                    end else begin
                        o_state.phase         = sfpp_pkg::PH_HALT;
                        o_res.valid           = 1'b1;
                        o_res.word.event_res  = sfpp_pkg::EV_ERROR;
                        o_res.word.error_code = is_text ? sfpp_pkg::ERR_TEXT_ESC
                                                        : sfpp_pkg::ERR_KEY_ESC;
                    end
                end
                sfpp_pkg::PH_KOCT1, sfpp_pkg::PH_TOCT1: begin
                    if (sfpp_pkg::is_octal(i_byte)) begin
                        o_state.oct   = {i_state.oct[1:0], i_byte[2:0]};
                        o_state.phase = is_text ? sfpp_pkg::PH_TOCT2 : sfpp_pkg::PH_KOCT2;
                    end else begin
                        o_state.phase         = sfpp_pkg::PH_HALT;
                        o_res.valid           = 1'b1;
                        o_res.word.event_res  = sfpp_pkg::EV_ERROR;
                        o_res.word.error_code = is_text ? sfpp_pkg::ERR_TEXT_ESC
                                                        : sfpp_pkg::ERR_KEY_ESC;
                    end
                end
                sfpp_pkg::PH_KOCT2, sfpp_pkg::PH_TOCT2: begin
                    if (sfpp_pkg::is_octal(i_byte)) begin
                        want_char     = 1'b1;
                        char_val      = {i_state.oct, i_byte[2:0]};
                        o_state.oct   = '0;
                        o_state.phase = is_text ? sfpp_pkg::PH_TEXT : sfpp_pkg::PH_KEY;
                    end else begin
                        o_state.phase         = sfpp_pkg::PH_HALT;
                        o_res.valid           = 1'b1;
                        o_res.word.event_res  = sfpp_pkg::EV_ERROR;
                        o_res.word.error_code = is_text ? sfpp_pkg::ERR_TEXT_ESC
                                                        : sfpp_pkg::ERR_KEY_ESC;
                    end
                end
                sfpp_pkg::PH_SEP1: begin
                    if (sfpp_pkg::is_ws(i_byte)) begin
                        o_state.line = sfpp_pkg::bump_line(i_state.line, i_byte);
                    end else if (i_byte == sfpp_pkg::CH_EQUAL) begin
                        o_state.phase = sfpp_pkg::PH_SEP2;
                    end else begin
                        o_state.phase         = sfpp_pkg::PH_HALT;
                        o_res.valid           = 1'b1;
                        o_res.word.event_res  = sfpp_pkg::EV_ERROR;
                        o_res.word.error_code = sfpp_pkg::ERR_NO_SEP;
                    end
                end
                sfpp_pkg::PH_SEP2: begin
                    if (sfpp_pkg::is_ws(i_byte)) begin
                        o_state.line = sfpp_pkg::bump_line(i_state.line, i_byte);
                    end else if (i_byte == sfpp_pkg::CH_QUOTE) begin
                        o_len         = '0;
                        o_state.phase = sfpp_pkg::PH_TEXT;
                    end else begin
                        o_state.phase         = sfpp_pkg::PH_HALT;
                        o_res.valid           = 1'b1;
                        o_res.word.event_res  = sfpp_pkg::EV_ERROR;
                        o_res.word.error_code = sfpp_pkg::ERR_NO_TEXT;
                    end
                end
                sfpp_pkg::PH_TERM: begin
                    if (i_byte == sfpp_pkg::CH_SEMI) begin
                        o_state.phase        = sfpp_pkg::PH_BETWEEN;
                        o_res.valid          = 1'b1;
                        o_res.word.event_res = sfpp_pkg::EV_PAIR_DONE;
                    end else begin
                        o_state.phase         = sfpp_pkg::PH_HALT;
                        o_res.valid           = 1'b1;
                        o_res.word.event_res  = sfpp_pkg::EV_ERROR;
                        o_res.word.error_code = sfpp_pkg::ERR_NO_TERM;
                    end
                end
                default: begin
                    o_state.phase = sfpp_pkg::PH_HALT;
                end
            endcase
        end

        // String character: dropped once the string is full
        char_ev = is_text ? sfpp_pkg::EV_TEXT_CHAR : sfpp_pkg::EV_KEY_CHAR;
        if (want_char && (i_len < LEN_LAST)) begin
            o_len                = i_len + LEN_W'(1);
            o_res.valid          = 1'b1;
            o_res.word.event_res = char_ev;
            o_res.word.out_char  = char_val;
        end
    end

endmodule

### design/sfpp_out_reg.sv
// ----------------------------------------------------------------------------
// Strings catalog parser output register
// Holds one event word until the sink takes it.
// ----------------------------------------------------------------------------
module sfpp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sfpp_pkg::t_result i_word,
    output logic              o_can_load,
    sfpp_out_if.source        o_out
);

    logic              r_valid;
    logic              n_valid;
    sfpp_pkg::t_result r_word;

    // Room when empty or when the held word leaves this cycle
    assign o_can_load = !r_valid || o_out.ready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.event_res   = r_word.event_res;
    assign o_out.out_char    = r_word.out_char;
    assign o_out.error_code  = r_word.error_code;
    assign o_out.line_number = r_word.line_number;

endmodule

### design/strings_file_pair_parser.sv
// ----------------------------------------------------------------------------
// Strings catalog parser
// Streaming parser for "key" = "text"; catalogs, one byte per word.
// ----------------------------------------------------------------------------
// Takes one catalog byte per clock and gives zero or one event word for each
// byte, in the cycle after the byte is accepted. The parse state is updated by
// one pass of decode logic per byte; the rate is limited only by the output
// register, which accepts a new byte whenever it is empty or its word is
// taken in the same cycle. Strings longer than MAX_LEN-1 characters have the
// excess dropped silently. After an error or end event the parser halts and
// consumes bytes with no output until reset. No clearing pass after reset.
module strings_file_pair_parser #(
    parameter int MAX_LEN = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sfpp_in_if.sink    i_in,
    sfpp_out_if.source o_out
);

    `include "strings_file_pair_parser_assert.svh"

    localparam int LEN_W = $clog2(MAX_LEN);

    sfpp_pkg::t_parse_state r_state;
    sfpp_pkg::t_parse_state n_state;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    sfpp_pkg::t_step_res    step_res;
    logic                   can_load;
    logic                   accept;

    assign i_in.ready = can_load;
    assign accept     = i_in.valid && can_load;

    // Per-byte decode
    sfpp_step #(
        .MAX_LEN (MAX_LEN)
    ) u_step (
        .i_state (r_state),
        .i_len   (r_len),
        .i_byte  (i_in.data_byte),
        .i_eod   (i_in.end_of_data),
        .o_state (n_state),
        .o_len   (n_len),
        .o_res   (step_res)
    );

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= sfpp_pkg::PH_BETWEEN;
            r_state.oct   <= '0;
            r_state.line  <= sfpp_pkg::LINE_W'(1);
            r_len         <= '0;
        end else if (accept) begin
            r_state <= n_state;
            r_len   <= n_len;
        end
    end

    // Event word register
    sfpp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && step_res.valid),
        .i_word     (step_res.word),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    // Checks
    `SFPP_ASSERT(a_halt_after_final,
        (accept && step_res.valid &&
         (step_res.word.event_res == sfpp_pkg::EV_ERROR ||
          step_res.word.event_res == sfpp_pkg::EV_END_OK))
        |=> (r_state.phase == sfpp_pkg::PH_HALT),
        "parser did not halt after final event")
    `SFPP_ASSERT(a_halt_silent,
        (r_state.phase == sfpp_pkg::PH_HALT) |-> !step_res.valid,
        "halted parser produced an event")
    `SFPP_ASSERT_ALWAYS(a_reset_state,
        !i_rst_n |=> (r_state.phase == sfpp_pkg::PH_BETWEEN &&
                      r_state.line == sfpp_pkg::LINE_W'(1)),
        "bad state after reset")

endmodule

### tb/strings_file_pair_parser_test.sv
// ----------------------------------------------------------------------------
// Strings catalog parser testbench
// Feeds catalog bytes through the input channel and checks every event word
// against a cycle-free software copy of the parser. Well-formed entries with
// random content, comments and whitespace make up most of the traffic; a
// single randomly chosen ending (clean end or one of the error paths) closes
// the run, followed by words that the halted parser must swallow silently.
// ----------------------------------------------------------------------------
module strings_file_pair_parser_test;
    import sfpp_pkg::*;

    localparam int         STR_MAX        = 1024;
    localparam int         TIMEOUT_CYCLES = 1_000_000;
    localparam logic [7:0] CH_VT          = 8'd11;
    localparam logic [7:0] CH_FF          = 8'd12;

    logic i_clk;
    logic i_rst_n;

    sfpp_in_if  in_ch ();
    sfpp_out_if out_ch ();

    strings_file_pair_parser #(
        .MAX_LEN (STR_MAX)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Parser copy and queue of event words still to come
    class parse_event_board;
        typedef struct {
            t_event      ev;
            logic [7:0]  ch;
            t_err        err;
            logic [19:0] ln;
        } parse_word_s;

        t_phase      phase;
        logic [7:0]  oct_acc;
        int unsigned str_len;
        logic [19:0] line_cnt;
        parse_word_s pending[$];
        int          fail_count;

        function new();
            phase      = PH_BETWEEN;
            oct_acc    = 8'h00;
            str_len    = 0;
            line_cnt   = 20'd1;
            fail_count = 0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        endfunction

        function void count_newline(logic [7:0] c);
            if ((c == CH_LF) && (line_cnt != LINE_MAX)) begin
                line_cnt++;
            end
        endfunction

        function void push_word(t_event ev, logic [7:0] ch, t_err err);
            parse_word_s w;
            w.ev  = ev;
            w.ch  = ch;
            w.err = err;
            w.ln  = line_cnt;
            pending.push_back(w);
        endfunction

        function void halt_with(t_err err);
            phase = PH_HALT;
            push_word(EV_ERROR, 8'h00, err);
        endfunction

        // Characters past the length cap are eaten without a word
        function void take_char(bit in_text, logic [7:0] ch);
            if (str_len < STR_MAX - 1) begin
                str_len++;
                push_word(in_text ? EV_TEXT_CHAR : EV_KEY_CHAR, ch, ERR_SYNTAX);
            end
        endfunction

        // Byte right after a backslash
        function void escape_first(bit in_text, logic [7:0] c);
            logic [7:0] ch;
            case (c)
                CH_BSLASH, CH_APOS, CH_QUOTE: ch = c;
                CH_N:                         ch = CH_LF;
                CH_R:                         ch = CH_CR;
                CH_T:                         ch = CH_TAB;
                default: begin
                    if ((c >= CH_ZERO) && (c <= CH_THREE)) begin
                        oct_acc = c - CH_ZERO;
                        phase   = in_text ? PH_TOCT1 : PH_KOCT1;
                    end else begin
                        halt_with(in_text ? ERR_TEXT_ESC : ERR_KEY_ESC);
                    end
                    return;
                end
            endcase
            phase = in_text ? PH_TEXT : PH_KEY;
            take_char(in_text, ch);
        endfunction

        // One accepted input word
        function void note_byte(logic [7:0] c, logic eod);
            bit in_text;
            if (phase == PH_HALT) begin
                return;
            end
            if (eod) begin
                case (phase)
                    PH_BETWEEN, PH_COMMENT, PH_CSTAR: begin
                        phase = PH_HALT;
                        push_word(EV_END_OK, 8'h00, ERR_SYNTAX);
                    end
                    PH_KEY, PH_KESC:             halt_with(ERR_OPEN_KEY);
                    PH_KOCT1, PH_KOCT2:          halt_with(ERR_KEY_ESC);
                    PH_SEP1:                     halt_with(ERR_NO_SEP);
                    PH_SEP2:                     halt_with(ERR_NO_TEXT);
                    PH_TEXT:                     halt_with(ERR_OPEN_TXT);
                    PH_TESC, PH_TOCT1, PH_TOCT2: halt_with(ERR_TEXT_ESC);
                    PH_TERM:                     halt_with(ERR_NO_TERM);
                    default:                     halt_with(ERR_SYNTAX); // lone slash
                endcase
                return;
            end
            in_text = phase inside {PH_TEXT, PH_TESC, PH_TOCT1, PH_TOCT2};
            case (phase)
                PH_BETWEEN: begin
                    if (is_blank(c)) begin
                        count_newline(c);
                    end else if (c == CH_SLASH) begin
                        phase = PH_SLASH;
                    end else if (c == CH_QUOTE) begin
                        str_len = 0;
                        phase   = PH_KEY;
                    end else begin
                        halt_with(ERR_SYNTAX);
                    end
                end
                PH_SLASH: begin
                    if (c == CH_STAR) begin
                        phase = PH_COMMENT;
                    end else begin
                        halt_with(ERR_SYNTAX);
                    end
                end
                PH_COMMENT: begin
                    if (c == CH_STAR) begin
                        phase = PH_CSTAR;
                    end else begin
                        count_newline(c);
                    end
                end
                PH_CSTAR: begin
                    if (c == CH_SLASH) begin
                        phase = PH_BETWEEN;
                    end else if (c != CH_STAR) begin
                        count_newline(c);
                        phase = PH_COMMENT;
                    end
                end
                PH_KEY, PH_TEXT: begin
                    if ((c == CH_QUOTE) && in_text) begin
                        phase = PH_TERM;
                    end else if (c == CH_QUOTE) begin
                        phase = PH_SEP1;
                        push_word(EV_KEY_DONE, 8'h00, ERR_SYNTAX);
                    end else if (c == CH_BSLASH) begin
                        phase = in_text ? PH_TESC : PH_KESC;
                    end else begin
                        take_char(in_text, c);
                    end
                end
                PH_KESC, PH_TESC: escape_first(in_text, c);
                PH_KOCT1, PH_TOCT1, PH_KOCT2, PH_TOCT2: begin
                    if ((c < CH_ZERO) || (c > CH_SEVEN)) begin
                        halt_with(in_text ? ERR_TEXT_ESC : ERR_KEY_ESC);
                    end else if ((phase == PH_KOCT1) || (phase == PH_TOCT1)) begin
                        oct_acc = {oct_acc[4:0], c[2:0]};
                        phase   = in_text ? PH_TOCT2 : PH_KOCT2;
                    end else begin
                        phase = in_text ? PH_TEXT : PH_KEY;
                        take_char(in_text, {oct_acc[4:0], c[2:0]});
                        oct_acc = 8'h00;
                    end
                end
                PH_SEP1: begin
                    if (is_blank(c)) begin
                        count_newline(c);
                    end else if (c == CH_EQUAL) begin
                        phase = PH_SEP2;
                    end else begin
                        halt_with(ERR_NO_SEP);
                    end
                end
                PH_SEP2: begin
                    if (is_blank(c)) begin
                        count_newline(c);
                    end else if (c == CH_QUOTE) begin
                        str_len = 0;
                        phase   = PH_TEXT;
                    end else begin
                        halt_with(ERR_NO_TEXT);
                    end
                end
                PH_TERM: begin
                    if (c == CH_SEMI) begin
                        phase = PH_BETWEEN;
                        push_word(EV_PAIR_DONE, 8'h00, ERR_SYNTAX);
                    end else begin
                        halt_with(ERR_NO_TERM);
                    end
                end
                default: phase = PH_HALT;
            endcase
        endfunction

        // One accepted output word against the oldest expectation
        function void check_event(logic [2:0] ev, logic [7:0] ch, logic [2:0] err,
                                  logic [19:0] ln);
            parse_word_s w;
            if (pending.size() == 0) begin
                $error("event word with none pending: event_res %0d out_char %0d", ev, ch);
                fail_count++;
                return;
            end
            w = pending.pop_front();
            if (ev !== w.ev) begin
                $error("event_res expected %0d got %0d", w.ev, ev);
                fail_count++;
            end
            if (ch !== w.ch) begin
                $error("out_char expected %0d got %0d", w.ch, ch);
                fail_count++;
            end
            if (err !== w.err) begin
                $error("error_code expected %0d got %0d", w.err, err);
                fail_count++;
            end
            if (ln !== w.ln) begin
                $error("line_number expected %0d got %0d", w.ln, ln);
                fail_count++;
            end
        endfunction
    endclass

    parse_event_board board;
    int src_idle_pct;
    int rcv_stall_pct;
    int hold_request;
    int words_sent;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("FAIL");
        $finish;
    end

    // Output side: random stalls, plus a long hold-off on request
    initial begin : sink_side
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.check_event(out_ch.event_res, out_ch.out_char, out_ch.error_code,
                              out_ch.line_number);
        end
    end

    // Offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] b, input logic eod);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.end_of_data <= eod;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_byte(b, eod);
        words_sent++;
    endtask

    task automatic put(input logic [7:0] b);
        send_word(b, 1'b0);
    endtask

    // Sender pauses until every pending word is out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending.size() != 0);
    endtask

    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while ((b == CH_QUOTE) || (b == CH_BSLASH));
        return b;
    endfunction

    // Random byte that is no blank and neither of two given bytes
    function automatic logic [7:0] rand_not(logic [7:0] a, logic [7:0] z);
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (board.is_blank(b) || (b == a) || (b == z));
        return b;
    endfunction

    function automatic logic [7:0] rand_bad_escape();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while ((b inside {CH_BSLASH, CH_APOS, CH_QUOTE, CH_N, CH_R, CH_T}) ||
               ((b >= CH_ZERO) && (b <= CH_THREE)));
        return b;
    endfunction

    function automatic logic [7:0] rand_non_octal();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while ((b >= CH_ZERO) && (b <= CH_SEVEN));
        return b;
    endfunction

    task automatic put_ws(input int n);
        repeat (n) begin
            case ($urandom_range(7))
                0, 1:    put(CH_LF);
                2:       put(CH_TAB);
                3:       put(CH_CR);
                4:       put(CH_VT);
                5:       put(CH_FF);
                default: put(CH_SPACE);
            endcase
        end
    endtask

    // Comment body never closes early: no slash right after a star
    task automatic put_comment(input int n);
        logic [7:0] b;
        logic [7:0] prev;
        prev = 8'h00;
        put(CH_SLASH);
        put(CH_STAR);
        repeat (n) begin
            b = ($urandom_range(3) == 0) ? CH_STAR : 8'($urandom_range(255));
            if ((prev == CH_STAR) && (b == CH_SLASH)) begin
                b = CH_LF;
            end
            put(b);
            prev = b;
        end
        put(CH_STAR);
        put(CH_SLASH);
    endtask

    // n decoded characters: plain bytes, simple escapes and octal escapes
    task automatic put_body(input int n);
        repeat (n) begin
            case ($urandom_range(9))
                6: begin
                    put(CH_BSLASH);
                    case ($urandom_range(5))
                        0:       put(CH_BSLASH);
                        1:       put(CH_APOS);
                        2:       put(CH_QUOTE);
                        3:       put(CH_N);
                        4:       put(CH_R);
                        default: put(CH_T);
                    endcase
                end
                7, 8: begin
                    put(CH_BSLASH);
                    put(CH_ZERO + 8'($urandom_range(3)));
                    put(CH_ZERO + 8'($urandom_range(7)));
                    put(CH_ZERO + 8'($urandom_range(7)));
                end
                default: put(rand_plain());
            endcase
        end
    endtask

    task automatic put_gap();
        put_ws($urandom_range(3));
        if ($urandom_range(3) == 0) begin
            put_comment($urandom_range(10));
            put_ws($urandom_range(2));
        end
    endtask

    task automatic put_entry(input int klen, input int tlen);
        put(CH_QUOTE);
        put_body(klen);
        put(CH_QUOTE);
        put_ws($urandom_range(2));
        put(CH_EQUAL);
        put_ws($urandom_range(2));
        put(CH_QUOTE);
        put_body(tlen);
        put(CH_QUOTE);
        put(CH_SEMI);
    endtask

    // Blanks of every kind, a comment that does not close on its first
    // slash, field extremes and octal extremes
    task automatic run_directed();
        logic [7:0] seq[$];
        seq = '{CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE,
                CH_SLASH, CH_STAR, CH_SLASH, CH_LF, CH_STAR, CH_STAR, CH_SLASH,
                CH_QUOTE, 8'h00, 8'hFF, CH_BSLASH, CH_APOS, CH_QUOTE,
                CH_EQUAL, CH_LF, CH_QUOTE, CH_BSLASH, CH_THREE, CH_SEVEN, CH_SEVEN,
                CH_BSLASH, CH_ZERO, CH_ZERO, CH_ZERO, CH_QUOTE, CH_SEMI};
        foreach (seq[i]) put(seq[i]);
    endtask

    // One idling setting; optionally with the long output hold-off first,
    // while the sender keeps offering an entry
    task automatic run_phase(input int src, input int rcv, input int budget, input bit press);
        int start_cnt;
        src_idle_pct  = src;
        rcv_stall_pct = rcv;
        if (press) begin
            hold_request = 80;
            put_entry(12, 20);
            put_gap();
        end
        start_cnt = words_sent;
        while (words_sent - start_cnt < budget) begin
            put_gap();
            put_entry($urandom_range(8), $urandom_range(12));
        end
        wait_drained();
    endtask

    // Prefix helpers for the closing case
    task automatic open_key();
        put(CH_QUOTE);
        put_body($urandom_range(3));
    endtask

    task automatic closed_key();
        open_key();
        put(CH_QUOTE);
        put_ws($urandom_range(2));
    endtask

    task automatic after_equal();
        closed_key();
        put(CH_EQUAL);
        put_ws($urandom_range(2));
    endtask

    task automatic open_text();
        after_equal();
        put(CH_QUOTE);
        put_body($urandom_range(3));
    endtask

    // One random way to finish; the end marker then either ends the parse
    // or lands on an already halted parser, as do the trailing words
    task automatic end_catalog();
        put_gap();
        case ($urandom_range(23))
            0: ;
            1: begin
                put(CH_SLASH);
                put(CH_STAR);
                put(CH_LF);
            end
            2: begin
                put(CH_SLASH);
                put(CH_STAR);
                put(CH_STAR);
            end
            3: begin
                put(CH_SLASH);
                put(rand_not(CH_STAR, CH_STAR));
            end
            4: put(CH_SLASH);
            5: put(rand_not(CH_SLASH, CH_QUOTE));
            6: open_key();
            7: begin
                open_key();
                put(CH_BSLASH);
            end
            8: begin
                open_key();
                put(CH_BSLASH);
                put(rand_bad_escape());
            end
            9: begin
                open_key();
                put(CH_BSLASH);
                put(CH_ZERO + 8'($urandom_range(4, 7)));
            end
            10: begin
                open_key();
                put(CH_BSLASH);
                put(CH_ZERO + 8'($urandom_range(3)));
                put(rand_non_octal());
            end
            11: begin
                open_key();
                put(CH_BSLASH);
                put(CH_ZERO + 8'($urandom_range(3)));
                if ($urandom_range(1)) put(CH_ZERO + 8'($urandom_range(7)));
            end
            12: begin
                closed_key();
                put(rand_not(CH_EQUAL, CH_EQUAL));
            end
            13: closed_key();
            14: begin
                after_equal();
                put(rand_not(CH_QUOTE, CH_QUOTE));
            end
            15: after_equal();
            16: open_text();
            17: begin
                open_text();
                put(CH_BSLASH);
            end
            18: begin
                open_text();
                put(CH_BSLASH);
                put(rand_bad_escape());
            end
            19: begin
                open_text();
                put(CH_BSLASH);
                put(CH_ZERO + 8'($urandom_range(4, 7)));
            end
            20: begin
                open_text();
                put(CH_BSLASH);
                put(CH_ZERO + 8'($urandom_range(3)));
                put(CH_ZERO + 8'($urandom_range(7)));
                put(rand_non_octal());
            end
            21: begin
                open_text();
                put(CH_QUOTE);
                put(rand_not(CH_SEMI, CH_SEMI));
            end
            22: begin
                open_text();
                put(CH_QUOTE);
            end
            default: begin
                open_text();
                put(CH_BSLASH);
                put(CH_ZERO + 8'($urandom_range(3)));
                if ($urandom_range(1)) put(CH_ZERO + 8'($urandom_range(7)));
            end
        endcase
        send_word(8'($urandom_range(255)), 1'b1);
        repeat (6) send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Main sequence
    initial begin : stimulus
        board         = new();
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_request  = 0;
        words_sent    = 0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.data_byte   <= 8'h00;
        in_ch.end_of_data <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_drained();
        run_phase(0, 0, 245, 1'b1);
        run_phase(86, 0, 245, 1'b0);
        run_phase(0, 86, 245, 1'b0);
        run_phase(17, 17, 245, 1'b0);
        end_catalog();

        // Let the last words out, then watch for strays
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (board.fail_count == 0 && board.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
